// ===== sv/adcp_pkg.sv =====
// Shared types, constants and column gather/scatter helpers for the
// adaptive DRAM column prefetcher. No dependencies.
package adcp_pkg;

  localparam int ADCP_COLUMNS_PER_ROW = 64;
  localparam int ADDR_W   = 48;
  localparam int COL_W    = 6;
  localparam int LEVEL_W  = 6;
  localparam int CNT_W    = 32;
  localparam int IN_DATA_W  = 56;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 48;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [LEVEL_W-1:0] MAX_LEVEL_RESET = 6'd4;
  localparam logic [CNT_W-1:0]   PERIOD_RESET    = 32'd1000;

  // action codes
  localparam logic [1:0] ACT_ACCESS = 2'd0;
  localparam logic [1:0] ACT_FILL   = 2'd1;
  localparam logic [1:0] ACT_TICK   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 1'd1;

  typedef struct packed {
    logic in_ready;
    logic cfg_ready;
    logic emit;
    logic div_step;
    logic emitting;
  } cmd_t;

  typedef struct packed {
    logic run_start;
    logic div_start;
    logic out_free;
    logic run_last;
    logic div_last;
    logic run_empty;
    logic in_pending;
  } status_t;

  // column bit 0 sits at address bit 7, bits 1..5 at address bits 12..16
  function automatic logic [COL_W-1:0] gather_column(input logic [ADDR_W-1:0] addr);
    return {addr[16:12], addr[7]};
  endfunction

  function automatic logic [ADDR_W-1:0] scatter_column(input logic [ADDR_W-1:0] addr,
                                                       input logic [COL_W-1:0]  col);
    logic [ADDR_W-1:0] res;
    res        = addr;
    res[7]     = col[0];
    res[16:12] = col[5:1];
    return res;
  endfunction

endpackage

// ===== sv/adcp_ctrl.sv =====
// Controller state machine of the column prefetcher: sequences prefetch runs
// and the period remainder recompute. Depends on adcp_pkg.
module adcp_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  adcp_pkg::status_t status,
  output adcp_pkg::cmd_t    cmd
);
  import adcp_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EMIT = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    cmd.in_ready  = (state == ST_IDLE);
    cmd.cfg_ready = (state == ST_IDLE) && !status.in_pending;
    cmd.emitting  = (state == ST_EMIT);
    cmd.emit      = (state == ST_EMIT) && status.out_free;
    cmd.div_step  = (state == ST_DIV);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        priority if (status.div_start) state_next = ST_DIV;
        else if (status.run_start)     state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free && status.run_last) state_next = ST_IDLE;
      end
      ST_DIV: begin
        if (status.div_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== sv/adcp_datapath.sv =====
// Datapath of the column prefetcher: config registers, feedback counters,
// tick phase with a bit-serial remainder unit, run registers and output stage.
// Depends on adcp_pkg.
module adcp_datapath #(
  parameter int COLUMNS_PER_ROW = adcp_pkg::ADCP_COLUMNS_PER_ROW
) (
  input  logic                               clk,
  input  logic                               rst,
  input  adcp_pkg::cmd_t                     cmd,
  output adcp_pkg::status_t                  status,
  input  logic                               s_axis_tvalid,
  input  logic [adcp_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  input  logic [adcp_pkg::IN_USER_W-1:0]     s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [adcp_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic                               m_axis_tlast,
  input  logic                               cfg_valid,
  input  logic [adcp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [adcp_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import adcp_pkg::*;

  localparam logic [COL_W:0] LIMIT = (COL_W+1)'(COLUMNS_PER_ROW - 1);

  // config and feedback state
  logic [LEVEL_W-1:0] max_level;
  logic [CNT_W-1:0]   period_ticks;
  logic [LEVEL_W-1:0] aggression;
  logic [CNT_W-1:0]   tick_count;
  logic [CNT_W-1:0]   phase;
  logic [CNT_W-1:0]   useful_count;
  logic [CNT_W-1:0]   evict_count;
  logic [CNT_W-1:0]   prior_evict_count;
  logic [4:0]         div_cnt;

  // run registers
  logic [ADDR_W-1:0]  base_addr;
  logic [COL_W-1:0]   next_col;
  logic [LEVEL_W-1:0] remain;

  logic               in_acc;
  logic               cfg_acc;
  logic [ADDR_W-1:0]  in_addr;
  logic [COL_W-1:0]   in_col;
  logic [COL_W:0]     avail;
  logic [LEVEL_W-1:0] run_len;
  logic               is_access, is_fill, is_tick;

  logic [CNT_W-1:0]   tick_next;
  logic [CNT_W:0]     phase_inc;
  logic               phase_wrap;
  logic               fire;
  logic [CNT_W+1:0]   lhs;
  logic [CNT_W+2:0]   rhs;

  logic [CNT_W:0]     rem_sh;
  logic [CNT_W-1:0]   rem_next;

  assign in_acc    = s_axis_tvalid && cmd.in_ready;
  assign cfg_acc   = cfg_valid && cmd.cfg_ready;
  assign in_addr   = s_axis_tdata[ADDR_W-1:0];
  assign is_access = (s_axis_tuser == ACT_ACCESS);
  assign is_fill   = (s_axis_tuser == ACT_FILL);
  assign is_tick   = (s_axis_tuser == ACT_TICK);

  // run length: columns between the accessed one and the last column of the row, capped by aggression
  always_comb begin
    in_col  = gather_column(in_addr);
    avail   = ({1'b0, in_col} < LIMIT) ? (LIMIT - (COL_W+1)'(1) - {1'b0, in_col}) : '0;
    run_len = (avail > {1'b0, aggression}) ? aggression : avail[LEVEL_W-1:0];
  end

  // tick phase tracks tick_count mod period_ticks
  always_comb begin
    tick_next  = tick_count + CNT_W'(1);
    phase_inc  = {1'b0, phase} + (CNT_W+1)'(1);
    phase_wrap = (tick_next == '0) || (phase_inc == {1'b0, period_ticks});
    fire       = (period_ticks != '0) && phase_wrap;
    lhs        = {prior_evict_count, 2'b00};
    rhs        = {1'b0, useful_count, 2'b00} + (CNT_W+3)'(useful_count);
  end

  // one restoring remainder step, MSB of tick_count first
  always_comb begin
    rem_sh   = {phase, tick_count[~div_cnt]};
    rem_next = (rem_sh >= {1'b0, period_ticks}) ? CNT_W'(rem_sh - {1'b0, period_ticks})
                                                : rem_sh[CNT_W-1:0];
  end

  always_comb begin
    status.run_start  = in_acc && is_access && (run_len != '0);
    status.run_empty  = in_acc && is_access && (run_len == '0);
    status.div_start  = cfg_acc && (cfg_index == REG_PERIOD) && (cfg_data != '0);
    status.out_free   = !m_axis_tvalid || m_axis_tready;
    status.run_last   = (remain == LEVEL_W'(1));
    status.div_last   = (div_cnt == 5'd31);
    status.in_pending = s_axis_tvalid;
  end

  // config, counters and phase
  always_ff @(posedge clk) begin
    if (rst) begin
      max_level         <= MAX_LEVEL_RESET;
      period_ticks      <= PERIOD_RESET;
      aggression        <= '0;
      tick_count        <= '0;
      phase             <= '0;
      useful_count      <= '0;
      evict_count       <= '0;
      prior_evict_count <= '0;
      div_cnt           <= '0;
    end else begin
      if (cfg_acc) begin
        unique case (cfg_index)
          REG_MAX_LEVEL: max_level <= cfg_data[LEVEL_W-1:0];
          REG_PERIOD: begin
            period_ticks <= cfg_data;
            phase        <= '0;
            div_cnt      <= '0;
          end
          default: ;
        endcase
      end
      if (cmd.div_step) begin
        phase   <= rem_next;
        div_cnt <= div_cnt + 5'd1;
      end
      if (in_acc) begin
        if (is_access && s_axis_tdata[48] && (useful_count != '1)) begin
          useful_count <= useful_count + CNT_W'(1);
        end
        if (is_fill && s_axis_tdata[49] && s_axis_tdata[50] && s_axis_tdata[51]
            && (evict_count != '1)) begin
          evict_count <= evict_count + CNT_W'(1);
        end
        if (is_tick) begin
          tick_count <= tick_next;
          phase      <= phase_wrap ? '0 : phase_inc[CNT_W-1:0];
          if (fire) begin
            if ({1'b0, lhs} > rhs) begin
              if (aggression != '0) aggression <= aggression - LEVEL_W'(1);
            end else if (aggression < max_level) begin
              aggression <= aggression + LEVEL_W'(1);
            end
            prior_evict_count <= evict_count;
            evict_count       <= '0;
            useful_count      <= '0;
          end
        end
      end
    end
  end

  // run registers
  always_ff @(posedge clk) begin
    if (status.run_start) begin
      base_addr <= in_addr;
      next_col  <= in_col + COL_W'(1);
      remain    <= run_len;
    end else if (cmd.emit) begin
      next_col <= next_col + COL_W'(1);
      remain   <= remain - LEVEL_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_axis_tdata <= scatter_column(base_addr, next_col);
      m_axis_tlast <= status.run_last;
    end
  end

endmodule

// ===== sv/adaptive_dram_column_prefetcher.sv =====
// Top level of the adaptive DRAM column prefetcher: joins controller and
// datapath. Depends on adcp_pkg, adcp_ctrl and adcp_datapath.
//
// After an access transaction the controller moves to its emit state and
// m_axis_tvalid rises with the first registered prefetch; the run then
// leaves at one prefetch per cycle while the sink takes them, and the input
// stays held off until the last prefetch of the run. Fills, ticks and
// accesses with no prefetch leave the input ready. A period_ticks write with
// a nonzero value starts a bit-serial remainder of the tick counter (one bit
// a cycle); input and config hold off during it. A config write waits while
// s_axis_tvalid is high. Reset is synchronous: counters and aggression clear,
// max_level returns to 4 and period_ticks to 1000; no clearing pass is needed.
module adaptive_dram_column_prefetcher #(
  parameter int COLUMNS_PER_ROW = adcp_pkg::ADCP_COLUMNS_PER_ROW
) (
  input  logic                            clk,
  input  logic                            rst,
  // tdata: access_address[47:0], was_useful[48], fill_by_prefetch[49],
  //        evicted_valid[50], tag_nonzero[51], zero[55:52]
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [adcp_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: action[1:0] (access, fill, tick)
  input  logic [adcp_pkg::IN_USER_W-1:0]  s_axis_tuser,
  // tdata: prefetch_address[47:0]; tlast: last_of_run
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [adcp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                            m_axis_tlast,
  // config writes: index 0 max_level, index 1 period_ticks
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [adcp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [adcp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import adcp_pkg::*;

  cmd_t    cmd;
  status_t status;

  // controller: pure sequencing, all handshakes gated from its state
  adcp_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  // datapath: every register but the controller state, and the arithmetic
  adcp_datapath #(
    .COLUMNS_PER_ROW (COLUMNS_PER_ROW)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  assign s_axis_tready = cmd.in_ready;
  assign cfg_ready     = cmd.cfg_ready;

  // a nonzero period write must lock out input while the remainder runs
  a_div_blocks_input: assert property (@(posedge clk) disable iff (rst)
    status.div_start |=> !s_axis_tready && !cfg_ready)
    else $error("input open during remainder recompute");

  // no new run may start while one is still emitting
  a_emit_has_work: assert property (@(posedge clk) disable iff (rst)
    cmd.emitting |-> !status.run_start)
    else $error("new run started while emitting");

  // an access with no prefetch leaves the output stage alone
  a_empty_run_quiet: assert property (@(posedge clk) disable iff (rst)
    status.run_empty && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("prefetch emitted for an empty run");

  // a run ends with the block back at the input
  a_last_returns: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && status.run_last |=> s_axis_tready)
    else $error("controller did not return after last prefetch");

endmodule
